/* rtl/dtu_pkg.sv */
`timescale 1ns / 1ps

package dtu_pkg;

  // character set chosen by the string header
  typedef enum logic [2:0] {
    CS_LATIN1   = 3'd0,
    CS_PART2    = 3'd1,
    CS_PART4    = 3'd2,
    CS_CYRILLIC = 3'd3,
    CS_GREEK    = 3'd4,
    CS_TURKISH  = 3'd5
  } cs_t;

  // header parser phase
  typedef enum logic [1:0] {
    PH_FIRST = 2'd0,
    PH_ZERO  = 2'd1,
    PH_PART  = 2'd2,
    PH_TEXT  = 2'd3
  } phase_t;

  // what the back end has to emit for one queued entry
  typedef enum logic [1:0] {
    OP_SINGLE = 2'd0,
    OP_PAIR   = 2'd1,
    OP_ERROR  = 2'd2
  } op_t;

  typedef struct packed {
    op_t        op;
    cs_t        cs;
    logic [7:0] data;
  } cmd_t;

  // header codes
  localparam logic [7:0] HDR_CYRILLIC = 8'h01;
  localparam logic [7:0] HDR_GREEK    = 8'h03;
  localparam logic [7:0] HDR_TURKISH  = 8'h05;
  localparam logic [7:0] HDR_PART     = 8'h10;
  localparam logic [7:0] HDR_TEXT_MIN = 8'h20;
  localparam logic [7:0] PART_2       = 8'h02;
  localparam logic [7:0] PART_4       = 8'h04;
  localparam logic [7:0] PART_5       = 8'h05;
  localparam logic [7:0] PART_7       = 8'h07;
  localparam logic [7:0] PART_9       = 8'h09;

  localparam int RomDepth = 96;

  // upper half 0xA0..0xFF, two UTF-8 bytes per code
  localparam logic [15:0] ROM_PART2 [RomDepth] = '{
    16'hC2A0, 16'hC484, 16'hCB98, 16'hC581, 16'hC2A4, 16'hC4BD, 16'hC59A, 16'hC2A7,
    16'hC2A8, 16'hC5A0, 16'hC59E, 16'hC5A4, 16'hC5B9, 16'hC2AD, 16'hC5BD, 16'hC5BB,
    16'hC2B0, 16'hC485, 16'hCB9B, 16'hC582, 16'hC2B4, 16'hC4BE, 16'hC59B, 16'hCB87,
    16'hC2B8, 16'hC5A1, 16'hC59F, 16'hC5A5, 16'hC5BA, 16'hCB9D, 16'hC5BE, 16'hC5BC,
    16'hC594, 16'hC381, 16'hC382, 16'hC482, 16'hC384, 16'hC4B9, 16'hC486, 16'hC387,
    16'hC48C, 16'hC389, 16'hC498, 16'hC38B, 16'hC49A, 16'hC38D, 16'hC38E, 16'hC48E,
    16'hC490, 16'hC583, 16'hC587, 16'hC393, 16'hC394, 16'hC590, 16'hC396, 16'hC397,
    16'hC598, 16'hC5AE, 16'hC39A, 16'hC5B0, 16'hC39C, 16'hC39D, 16'hC5A2, 16'hC39F,
    16'hC595, 16'hC3A1, 16'hC3A2, 16'hC483, 16'hC3A4, 16'hC4BA, 16'hC487, 16'hC3A7,
    16'hC48D, 16'hC3A9, 16'hC499, 16'hC3AB, 16'hC49B, 16'hC3AD, 16'hC3AE, 16'hC48F,
    16'hC491, 16'hC584, 16'hC588, 16'hC3B3, 16'hC3B4, 16'hC591, 16'hC3B6, 16'hC3B7,
    16'hC599, 16'hC5AF, 16'hC3BA, 16'hC5B1, 16'hC3BC, 16'hC3BD, 16'hC5A3, 16'hCB99
  };

  localparam logic [15:0] ROM_PART4 [RomDepth] = '{
    16'hC2A0, 16'hC484, 16'hC4B8, 16'hC596, 16'hC2A4, 16'hC4A8, 16'hC4BB, 16'hC2A7,
    16'hC2A8, 16'hC5A0, 16'hC492, 16'hC4A2, 16'hC5A6, 16'hC2AD, 16'hC5BD, 16'hC2AF,
    16'hC2B0, 16'hC485, 16'hCB9B, 16'hC597, 16'hC2B4, 16'hC4A9, 16'hC4BC, 16'hCB87,
    16'hC2B8, 16'hC5A1, 16'hC493, 16'hC4A3, 16'hC5A7, 16'hC58A, 16'hC5BE, 16'hC58B,
    16'hC480, 16'hC381, 16'hC382, 16'hC383, 16'hC384, 16'hC385, 16'hC386, 16'hC4AE,
    16'hC48C, 16'hC389, 16'hC498, 16'hC38B, 16'hC496, 16'hC38D, 16'hC38E, 16'hC4AA,
    16'hC490, 16'hC585, 16'hC58C, 16'hC4B6, 16'hC394, 16'hC395, 16'hC396, 16'hC397,
    16'hC398, 16'hC5B2, 16'hC39A, 16'hC39B, 16'hC39C, 16'hC5A8, 16'hC5AA, 16'hC39F,
    16'hC481, 16'hC3A1, 16'hC3A2, 16'hC3A3, 16'hC3A4, 16'hC3A5, 16'hC3A6, 16'hC4AF,
    16'hC48D, 16'hC3A9, 16'hC499, 16'hC3AB, 16'hC497, 16'hC3AD, 16'hC3AE, 16'hC4AB,
    16'hC491, 16'hC586, 16'hC58D, 16'hC4B7, 16'hC3B4, 16'hC3B5, 16'hC3B6, 16'hC3B7,
    16'hC3B8, 16'hC5B3, 16'hC3BA, 16'hC3BB, 16'hC3BC, 16'hC5A9, 16'hC5AB, 16'hCB99
  };

  // two-byte UTF-8 sequence for a code 0x80..0xFF that is not dropped
  function automatic logic [15:0] dtu_pair(cs_t cs, logic [7:0] c);
    logic [6:0]  idx;
    logic [15:0] r;
    idx = c[6:0] - 7'h20;
    r   = {8'hC0 | {6'd0, c[7:6]}, 8'h80 | {2'd0, c[5:0]}};
    case (cs)
      CS_PART2: r = ROM_PART2[idx];
      CS_PART4: r = ROM_PART4[idx];
      CS_CYRILLIC: begin
        if (c >= 8'hE0) begin
          r = {8'hD1, 8'h80 | {3'd0, c[4:0]}};
        end else if (c >= 8'hC0) begin
          r = {8'hD0, 8'hA0 | {3'd0, c[4:0]}};
        end else begin
          r = {8'hD0, 8'h80 | {3'd0, c[4:0]}};
        end
      end
      CS_GREEK: begin
        if (c >= 8'hF0) begin
          r = {8'hCF, c - 8'h70};
        end else begin
          r = {8'hCE, c - 8'h30};
        end
      end
      CS_TURKISH: begin
        case (c)
          8'hD0:   r = 16'hC49E;
          8'hDD:   r = 16'hC4B0;
          8'hDE:   r = 16'hC59E;
          8'hF0:   r = 16'hC49F;
          8'hFD:   r = 16'hC4B1;
          8'hFE:   r = 16'hC59F;
          default: r = {8'hC0 | {6'd0, c[7:6]}, 8'h80 | {2'd0, c[5:0]}};
        endcase
      end
      default: r = {8'hC0 | {6'd0, c[7:6]}, 8'h80 | {2'd0, c[5:0]}};
    endcase
    return r;
  endfunction

endpackage

/* rtl/dtu_if.sv */
`timescale 1ns / 1ps

interface dtu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_in_string;

  modport source (output valid, output in_byte, output last_in_string, input ready);
  modport sink (input valid, input in_byte, input last_in_string, output ready);
endinterface

interface dtu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       charset_error;

  modport source (output valid, output out_byte, output last_of_run, output charset_error,
                  input ready);
  modport sink (input valid, input out_byte, input last_of_run, input charset_error,
                output ready);
endinterface

/* rtl/dtu_front.sv */
`timescale 1ns / 1ps

module dtu_front
  import dtu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] in_byte,
  input  logic       last_in_string,
  output logic       push,
  output cmd_t       push_cmd
);

  phase_t phase, phase_next;
  cs_t    cs, cs_next;
  logic   stopped, stopped_next;
  cs_t    text_cs;
  logic   text_drop;
  logic   emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_FIRST;
      cs      <= CS_LATIN1;
      stopped <= 1'b0;
    end else if (fire) begin
      phase   <= phase_next;
      cs      <= cs_next;
      stopped <= stopped_next;
    end
  end

  // a first byte of 0x20 or more is latin-1 text
  assign text_cs   = (phase == PH_FIRST) ? CS_LATIN1 : cs;
  assign text_drop = (in_byte[7:5] == 3'b100) &&
                     (text_cs inside {CS_PART2, CS_PART4, CS_CYRILLIC, CS_TURKISH});

  always_comb begin
    phase_next   = phase;
    cs_next      = cs;
    stopped_next = stopped;
    emit         = 1'b0;
    push_cmd     = '{op: OP_SINGLE, cs: text_cs, data: in_byte};

    case (phase)
      PH_FIRST: begin
        phase_next = PH_TEXT;
        if (in_byte >= HDR_TEXT_MIN) begin
          cs_next = CS_LATIN1;
          emit    = 1'b1;
          if (in_byte[7]) push_cmd.op = OP_PAIR;
        end else if (in_byte == HDR_PART) begin
          phase_next = PH_ZERO;
        end else if (in_byte == HDR_CYRILLIC) begin
          cs_next = CS_CYRILLIC;
        end else if (in_byte == HDR_GREEK) begin
          cs_next = CS_GREEK;
        end else if (in_byte == HDR_TURKISH) begin
          cs_next = CS_TURKISH;
        end else begin
          emit         = 1'b1;
          push_cmd.op  = OP_ERROR;
          stopped_next = 1'b1;
        end
      end
      PH_ZERO: begin
        if (in_byte == 8'h00) begin
          phase_next = PH_PART;
        end else begin
          phase_next   = PH_TEXT;
          emit         = 1'b1;
          push_cmd.op  = OP_ERROR;
          stopped_next = 1'b1;
        end
      end
      PH_PART: begin
        phase_next = PH_TEXT;
        case (in_byte)
          PART_2:  cs_next = CS_PART2;
          PART_4:  cs_next = CS_PART4;
          PART_5:  cs_next = CS_CYRILLIC;
          PART_7:  cs_next = CS_GREEK;
          PART_9:  cs_next = CS_TURKISH;
          default: begin
            emit         = 1'b1;
            push_cmd.op  = OP_ERROR;
            stopped_next = 1'b1;
          end
        endcase
      end
      default: begin
        if (!stopped) begin
          if (in_byte == 8'h00) begin
            stopped_next = 1'b1;
          end else if (!in_byte[7]) begin
            emit = 1'b1;
          end else if (!text_drop) begin
            emit        = 1'b1;
            push_cmd.op = OP_PAIR;
          end
        end
      end
    endcase

    if (last_in_string) begin
      // header cut short by the end of the string
      if (phase_next == PH_ZERO || phase_next == PH_PART) begin
        emit        = 1'b1;
        push_cmd.op = OP_ERROR;
      end
      phase_next   = PH_FIRST;
      cs_next      = CS_LATIN1;
      stopped_next = 1'b0;
    end
  end

  assign push = fire && emit;

endmodule

/* rtl/dtu_queue.sv */
`timescale 1ns / 1ps

module dtu_queue
  import dtu_pkg::*;
#(
  parameter int Depth = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic full,
  output logic empty
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  cmd_t            entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full  = (count == CntW'(Depth));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

/* rtl/dtu_back.sv */
`timescale 1ns / 1ps

module dtu_back
  import dtu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       head,
  input  logic       empty,
  output logic       pop,
  input  logic       out_ready,
  output logic       out_valid,
  output logic [7:0] out_byte,
  output logic       last_of_run,
  output logic       charset_error
);

  logic        second_half;
  logic        load;
  logic [15:0] pair;

  assign pair = dtu_pair(head.cs, head.data);
  assign load = !out_valid || out_ready;
  assign pop  = load && !empty && ((head.op != OP_PAIR) || second_half);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      second_half <= 1'b0;
    end else if (load) begin
      out_valid <= !empty;
      if (!empty && head.op == OP_PAIR) second_half <= !second_half;
    end
  end

  always_ff @(posedge clk) begin
    if (load && !empty) begin
      case (head.op)
        OP_PAIR: begin
          out_byte      <= second_half ? pair[7:0] : pair[15:8];
          last_of_run   <= second_half;
          charset_error <= 1'b0;
        end
        OP_ERROR: begin
          out_byte      <= 8'h00;
          last_of_run   <= 1'b1;
          charset_error <= 1'b1;
        end
        default: begin
          out_byte      <= head.data;
          last_of_run   <= 1'b1;
          charset_error <= 1'b0;
        end
      endcase
    end
  end

endmodule

/* rtl/dvb_text_iso8859_to_utf8.sv */
`timescale 1ns / 1ps

// channel   dir  fields                                    transfer when
// in_ch     in   in_byte[7:0], last_in_string              valid && ready
// out_ch    out  out_byte[7:0], last_of_run, charset_error  valid && ready
//
// an ascii byte or an error gives one output byte, a two-byte utf-8 code gives two;
// the byte-wide output register sets the rate and holds its byte while out_ch.ready is low
// valid header codes and dropped bytes give no output byte
// rst is synchronous: header parser, queue pointers and output valid clear
// a stalled output fills the command queue, after which in_ch.ready drops

module dvb_text_iso8859_to_utf8
  import dtu_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input logic       clk,
  input logic       rst,
  dtu_in_if.sink    in_ch,
  dtu_out_if.source out_ch
);

  logic in_fire;
  logic push;
  cmd_t push_cmd;
  logic pop;
  cmd_t head;
  logic q_full;
  logic q_empty;

  // front keeps taking bytes as long as the queue has room
  assign in_ch.ready = !q_full;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // header parser and byte classifier
  dtu_front u_front (
    .clk            (clk),
    .rst            (rst),
    .fire           (in_fire),
    .in_byte        (in_ch.in_byte),
    .last_in_string (in_ch.last_in_string),
    .push           (push),
    .push_cmd       (push_cmd)
  );

  // short command queue decoupling parser and emitter
  dtu_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // table lookup and utf-8 byte emitter with output register
  dtu_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .empty         (q_empty),
    .pop           (pop),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .out_byte      (out_ch.out_byte),
    .last_of_run   (out_ch.last_of_run),
    .charset_error (out_ch.charset_error)
  );

`ifndef NO_ASSERTIONS
  // the front only pushes on an input transfer, which needs queue room
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && q_full))
    else $error("command queue overflow");

  // second byte of a pair follows its first byte without a gap
  a_pair_back_to_back: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.ready && !out_ch.last_of_run) |=> out_ch.valid)
    else $error("second byte of a pair missing");

  // an error result is a single zero byte
  a_error_form: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.charset_error) |-> (out_ch.last_of_run && out_ch.out_byte == 8'h00))
    else $error("malformed error result");

  // nothing is popped from an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && q_empty))
    else $error("command queue underflow");
`endif

endmodule

/* bench/tb_dvb_text_iso8859_to_utf8.sv */
`timescale 1ns / 1ps

module tb_dvb_text_iso8859_to_utf8;
  import dtu_pkg::*;

  localparam int DIRECTED_ROWS = 26;
  localparam int RANDOM_ITEMS  = 450;
  // no idling on either side once this many bytes have gone in
  localparam int QUIET_FROM    = DIRECTED_ROWS + RANDOM_ITEMS - 80;
  // cycles the block may still need after the last result we wait for
  localparam int DRAIN_CYCLES  = 20;

  // one utf-8 result as it leaves the block
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } utf8_res_t;

  // one input byte, with an optional typed-in expectation
  typedef struct packed {
    logic [7:0] data;
    logic       fin;
    logic       typed;
    logic [1:0] n;
    logic [7:0] e0;
    logic [7:0] e1;
    logic       err;
  } text_row_t;

  // iso 8859-2 upper half, 0xA0..0xFF
  localparam logic [15:0] UTF8_PART2 [96] = '{
    16'hC2A0, 16'hC484, 16'hCB98, 16'hC581, 16'hC2A4, 16'hC4BD, 16'hC59A, 16'hC2A7,
    16'hC2A8, 16'hC5A0, 16'hC59E, 16'hC5A4, 16'hC5B9, 16'hC2AD, 16'hC5BD, 16'hC5BB,
    16'hC2B0, 16'hC485, 16'hCB9B, 16'hC582, 16'hC2B4, 16'hC4BE, 16'hC59B, 16'hCB87,
    16'hC2B8, 16'hC5A1, 16'hC59F, 16'hC5A5, 16'hC5BA, 16'hCB9D, 16'hC5BE, 16'hC5BC,
    16'hC594, 16'hC381, 16'hC382, 16'hC482, 16'hC384, 16'hC4B9, 16'hC486, 16'hC387,
    16'hC48C, 16'hC389, 16'hC498, 16'hC38B, 16'hC49A, 16'hC38D, 16'hC38E, 16'hC48E,
    16'hC490, 16'hC583, 16'hC587, 16'hC393, 16'hC394, 16'hC590, 16'hC396, 16'hC397,
    16'hC598, 16'hC5AE, 16'hC39A, 16'hC5B0, 16'hC39C, 16'hC39D, 16'hC5A2, 16'hC39F,
    16'hC595, 16'hC3A1, 16'hC3A2, 16'hC483, 16'hC3A4, 16'hC4BA, 16'hC487, 16'hC3A7,
    16'hC48D, 16'hC3A9, 16'hC499, 16'hC3AB, 16'hC49B, 16'hC3AD, 16'hC3AE, 16'hC48F,
    16'hC491, 16'hC584, 16'hC588, 16'hC3B3, 16'hC3B4, 16'hC591, 16'hC3B6, 16'hC3B7,
    16'hC599, 16'hC5AF, 16'hC3BA, 16'hC5B1, 16'hC3BC, 16'hC3BD, 16'hC5A3, 16'hCB99
  };

  // iso 8859-4 upper half, 0xA0..0xFF
  localparam logic [15:0] UTF8_PART4 [96] = '{
    16'hC2A0, 16'hC484, 16'hC4B8, 16'hC596, 16'hC2A4, 16'hC4A8, 16'hC4BB, 16'hC2A7,
    16'hC2A8, 16'hC5A0, 16'hC492, 16'hC4A2, 16'hC5A6, 16'hC2AD, 16'hC5BD, 16'hC2AF,
    16'hC2B0, 16'hC485, 16'hCB9B, 16'hC597, 16'hC2B4, 16'hC4A9, 16'hC4BC, 16'hCB87,
    16'hC2B8, 16'hC5A1, 16'hC493, 16'hC4A3, 16'hC5A7, 16'hC58A, 16'hC5BE, 16'hC58B,
    16'hC480, 16'hC381, 16'hC382, 16'hC383, 16'hC384, 16'hC385, 16'hC386, 16'hC4AE,
    16'hC48C, 16'hC389, 16'hC498, 16'hC38B, 16'hC496, 16'hC38D, 16'hC38E, 16'hC4AA,
    16'hC490, 16'hC585, 16'hC58C, 16'hC4B6, 16'hC394, 16'hC395, 16'hC396, 16'hC397,
    16'hC398, 16'hC5B2, 16'hC39A, 16'hC39B, 16'hC39C, 16'hC5A8, 16'hC5AA, 16'hC39F,
    16'hC481, 16'hC3A1, 16'hC3A2, 16'hC3A3, 16'hC3A4, 16'hC3A5, 16'hC3A6, 16'hC4AF,
    16'hC48D, 16'hC3A9, 16'hC499, 16'hC3AB, 16'hC497, 16'hC3AD, 16'hC3AE, 16'hC4AB,
    16'hC491, 16'hC586, 16'hC58D, 16'hC4B7, 16'hC3B4, 16'hC3B5, 16'hC3B6, 16'hC3B7,
    16'hC3B8, 16'hC5B3, 16'hC3BA, 16'hC3BB, 16'hC3BC, 16'hC5A9, 16'hC5AB, 16'hCB99
  };

  // directed strings: data, last, typed, count, first, second, error
  // rows with typed = 0 are left to the predictor
  text_row_t directed_rows [DIRECTED_ROWS] = '{
    '{8'h41, 1'b1, 1'b1, 2'd1, 8'h41, 8'h00, 1'b0},  // plain ascii right after reset
    '{8'hFF, 1'b0, 1'b1, 2'd2, 8'hC3, 8'hBF, 1'b0},  // top latin-1 code as header byte
    '{8'h00, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 1'b0},  // nul silences the string
    '{8'h80, 1'b1, 1'b1, 2'd0, 8'h00, 8'h00, 1'b0},  // nothing after the nul
    '{8'h1F, 1'b1, 1'b1, 2'd1, 8'h00, 8'h00, 1'b1},  // unknown first byte
    '{8'h10, 1'b1, 1'b1, 2'd1, 8'h00, 8'h00, 1'b1},  // string ends right after 0x10
    '{8'h10, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 1'b0},
    '{8'h01, 1'b1, 1'b1, 2'd1, 8'h00, 8'h00, 1'b1},  // wrong byte after 0x10
    '{8'h10, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 1'b0},  // part 2
    '{8'h00, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 1'b0},
    '{8'h02, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 1'b0},
    '{8'hA0, 1'b0, 1'b1, 2'd2, 8'hC2, 8'hA0, 1'b0},  // first table entry
    '{8'h9F, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 1'b0},  // control range dropped
    '{8'hFF, 1'b1, 1'b1, 2'd2, 8'hCB, 8'h99, 1'b0},  // last table entry
    '{8'h10, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 1'b0},  // part 4
    '{8'h00, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 1'b0},
    '{8'h04, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 1'b0},
    '{8'hFF, 1'b1, 1'b1, 2'd2, 8'hCB, 8'h99, 1'b0},
    '{8'h01, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 1'b0},  // cyrillic
    '{8'hC0, 1'b1, 1'b0, 2'd0, 8'h00, 8'h00, 1'b0},
    '{8'h03, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 1'b0},  // greek, second plane
    '{8'hF0, 1'b1, 1'b0, 2'd0, 8'h00, 8'h00, 1'b0},
    '{8'h05, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 1'b0},  // turkish substitute letter
    '{8'hDD, 1'b1, 1'b0, 2'd0, 8'h00, 8'h00, 1'b0},
    '{8'h10, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 1'b0},
    '{8'h00, 1'b1, 1'b1, 2'd1, 8'h00, 8'h00, 1'b1}   // string ends before the part number
  };

  bit   clk = 1'b0;
  logic rst;

  dtu_in_if  in_ch ();
  dtu_out_if out_ch ();

  dvb_text_iso8859_to_utf8 dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state, a copy of the block's header parser
  phase_t hdr_phase = PH_FIRST;
  cs_t    cur_cs    = CS_LATIN1;
  bit     muted     = 1'b0;

  utf8_res_t expected_utf8 [$];
  int        mismatches = 0;
  int        bytes_sent = 0;
  bit        idle_on    = 1'b1;

  function automatic logic [15:0] latin1_utf8(input logic [7:0] c);
    return {8'hC0 | {6'd0, c[7:6]}, 8'h80 | {2'd0, c[5:0]}};
  endfunction

  // one text byte under the current charset; returns how many bytes it gives
  function automatic int text_utf8(input logic [7:0] c, output logic [15:0] pair);
    logic [7:0] lo;
    pair = latin1_utf8(c);
    if (c == 8'h00) begin
      muted = 1'b1;
      return 0;
    end
    if (c < 8'h80) begin
      pair = {8'h00, c};
      return 1;
    end
    // c1 controls are dropped everywhere except latin-1 and greek
    if ((cur_cs inside {CS_PART2, CS_PART4, CS_CYRILLIC, CS_TURKISH}) && c < 8'hA0) begin
      return 0;
    end
    case (cur_cs)
      CS_PART2: pair = UTF8_PART2[7'(c - 8'hA0)];
      CS_PART4: pair = UTF8_PART4[7'(c - 8'hA0)];
      CS_CYRILLIC: begin
        lo = 8'h80 | (c & 8'h1F);
        if (c >= 8'hE0) begin
          pair = {8'hD1, lo};
        end else if (c >= 8'hC0) begin
          pair = {8'hD0, lo | 8'h20};
        end else begin
          pair = {8'hD0, lo};
        end
      end
      CS_GREEK: begin
        // the c1 range is not dropped and maps to low bytes 0x50..0x6F
        lo = c - 8'h30;
        if (c >= 8'hF0) begin
          pair = {8'hCF, lo - 8'h40};
        end else begin
          pair = {8'hCE, lo};
        end
      end
      CS_TURKISH: begin
        case (c)
          8'hD0:   pair = 16'hC49E;
          8'hDD:   pair = 16'hC4B0;
          8'hDE:   pair = 16'hC59E;
          8'hF0:   pair = 16'hC49F;
          8'hFD:   pair = 16'hC4B1;
          8'hFE:   pair = 16'hC59F;
          default: pair = latin1_utf8(c);
        endcase
      end
      default: pair = latin1_utf8(c);
    endcase
    return 2;
  endfunction

  // advance the copy of the parser by one accepted byte, hand back its results
  function automatic int predict_utf8(input logic [7:0] b, input logic fin,
                                      output utf8_res_t r0, output utf8_res_t r1);
    int          n;
    bit          bad;
    logic [15:0] pair;
    n    = 0;
    bad  = 1'b0;
    pair = 16'h0000;
    r0   = '0;
    r1   = '0;
    case (hdr_phase)
      PH_FIRST: begin
        hdr_phase = PH_TEXT;
        if (b >= HDR_TEXT_MIN) begin
          // latin-1 header byte is text as well
          cur_cs = CS_LATIN1;
          n = text_utf8(b, pair);
        end else if (b == HDR_PART) begin
          hdr_phase = PH_ZERO;
        end else if (b == HDR_CYRILLIC) begin
          cur_cs = CS_CYRILLIC;
        end else if (b == HDR_GREEK) begin
          cur_cs = CS_GREEK;
        end else if (b == HDR_TURKISH) begin
          cur_cs = CS_TURKISH;
        end else begin
          bad = 1'b1;
        end
      end
      PH_ZERO: begin
        if (b == 8'h00) begin
          hdr_phase = PH_PART;
        end else begin
          hdr_phase = PH_TEXT;
          bad = 1'b1;
        end
      end
      PH_PART: begin
        hdr_phase = PH_TEXT;
        case (b)
          PART_2:  cur_cs = CS_PART2;
          PART_4:  cur_cs = CS_PART4;
          PART_5:  cur_cs = CS_CYRILLIC;
          PART_7:  cur_cs = CS_GREEK;
          PART_9:  cur_cs = CS_TURKISH;
          default: bad = 1'b1;
        endcase
      end
      default: begin
        if (!muted) begin
          n = text_utf8(b, pair);
        end
      end
    endcase
    if (bad) begin
      muted = 1'b1;
    end
    if (fin) begin
      // a header cut short by the end of the string is an error too
      if (hdr_phase == PH_ZERO || hdr_phase == PH_PART) begin
        bad = 1'b1;
      end
      hdr_phase = PH_FIRST;
      cur_cs    = CS_LATIN1;
      muted     = 1'b0;
    end
    if (bad) begin
      r0 = '{8'h00, 1'b1, 1'b1};
      return 1;
    end
    if (n == 1) begin
      r0 = '{pair[7:0], 1'b1, 1'b0};
    end else if (n == 2) begin
      r0 = '{pair[15:8], 1'b0, 1'b0};
      r1 = '{pair[7:0], 1'b1, 1'b0};
    end
    return n;
  endfunction

  // offer one byte, wait for its transfer, then queue what it should give
  task automatic send_byte(input text_row_t row);
    int        gap;
    int        n;
    utf8_res_t r0;
    utf8_res_t r1;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.in_byte        <= row.data;
    in_ch.last_in_string <= row.fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
    n = predict_utf8(row.data, row.fin, r0, r1);
    if (row.typed) begin
      // typed rows still step the predictor so its state stays in line
      if (row.err) begin
        expected_utf8.push_back('{8'h00, 1'b1, 1'b1});
      end else if (row.n == 2'd1) begin
        expected_utf8.push_back('{row.e0, 1'b1, 1'b0});
      end else if (row.n == 2'd2) begin
        expected_utf8.push_back('{row.e0, 1'b0, 1'b0});
        expected_utf8.push_back('{row.e1, 1'b1, 1'b0});
      end
    end else begin
      if (n >= 1) expected_utf8.push_back(r0);
      if (n == 2) expected_utf8.push_back(r1);
    end
  endtask

  // mostly well-formed headers with random text, some broken or noisy ones
  task automatic send_random_string();
    logic [7:0] str [$];
    logic [7:0] b;
    int         kind;
    int         len;
    int         pick;
    text_row_t  row;
    kind = $urandom_range(0, 19);
    if (kind < 5) begin
      b = 8'($urandom_range(32, 255));
      str.push_back(b);
    end else if (kind < 8) begin
      case ($urandom_range(0, 2))
        0:       str.push_back(HDR_CYRILLIC);
        1:       str.push_back(HDR_GREEK);
        default: str.push_back(HDR_TURKISH);
      endcase
    end else if (kind < 15) begin
      str.push_back(HDR_PART);
      str.push_back(8'h00);
      case ($urandom_range(0, 4))
        0:       str.push_back(PART_2);
        1:       str.push_back(PART_4);
        2:       str.push_back(PART_5);
        3:       str.push_back(PART_7);
        default: str.push_back(PART_9);
      endcase
    end else if (kind == 15) begin
      // any control byte as header, valid or not
      b = 8'($urandom_range(0, 31));
      str.push_back(b);
    end else if (kind == 16) begin
      str.push_back(HDR_PART);
      b = 8'($urandom_range(0, 255));
      str.push_back(b);
    end else if (kind == 17) begin
      str.push_back(HDR_PART);
      str.push_back(8'h00);
      b = 8'($urandom_range(0, 255));
      str.push_back(b);
    end else if (kind == 18) begin
      // header cut short
      str.push_back(HDR_PART);
      if ($urandom_range(0, 1) == 1) str.push_back(8'h00);
    end else begin
      b = 8'($urandom_range(0, 255));
      str.push_back(b);
    end
    len = (kind == 18) ? 0 : $urandom_range(0, 8);
    repeat (len) begin
      pick = $urandom_range(0, 15);
      if (pick == 0) begin
        b = ($urandom_range(0, 1) == 1) ? 8'h00 : 8'($urandom_range(1, 31));
      end else if (pick < 4) begin
        b = 8'($urandom_range(128, 159));
      end else if (pick < 8) begin
        b = 8'($urandom_range(1, 127));
      end else begin
        b = 8'($urandom_range(160, 255));
      end
      str.push_back(b);
    end
    foreach (str[i]) begin
      row = '{str[i], (i == str.size() - 1), 1'b0, 2'd0, 8'h00, 8'h00, 1'b0};
      send_byte(row);
    end
  endtask

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 40) begin
        $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
      end
    end
  endfunction

  // sender side: directed table, then random strings, then drain
  initial begin
    rst                  = 1'b1;
    in_ch.valid          = 1'b0;
    in_ch.in_byte        = 8'h00;
    in_ch.last_in_string = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i]);
    end

    while (bytes_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
      // some strings run with no idling at all, and none near the end
      idle_on = (bytes_sent < QUIET_FROM) && ($urandom_range(0, 4) != 0);
      send_random_string();
    end
    idle_on = 1'b0;
    in_ch.valid <= 1'b0;

    while (expected_utf8.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_utf8.size() == 0) begin
      $display("dvb_text_iso8859_to_utf8 test passed");
    end else begin
      $display("dvb_text_iso8859_to_utf8 test failed");
    end
    $finish;
  end

  // receiver side: ready drops in random bursts, started only while idling is on
  initial begin
    int stall;
    stall        = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 14) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // every output transfer is matched against the oldest queued expectation
  always @(posedge clk) begin
    utf8_res_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_utf8.size() == 0) begin
        mismatches++;
        if (mismatches <= 40) begin
          $display("%0t ns: no result expected, got out_byte %h last_of_run %b charset_error %b",
                   $time, out_ch.out_byte, out_ch.last_of_run, out_ch.charset_error);
        end
      end else begin
        want = expected_utf8.pop_front();
        check_field("out_byte", want.data, out_ch.out_byte);
        check_field("last_of_run", {7'd0, want.last}, {7'd0, out_ch.last_of_run});
        check_field("charset_error", {7'd0, want.err}, {7'd0, out_ch.charset_error});
      end
    end
  end

  // hard stop far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("dvb_text_iso8859_to_utf8 test failed");
    $finish;
  end

endmodule

/* filelist.f */
rtl/dtu_pkg.sv
rtl/dtu_if.sv
rtl/dtu_front.sv
rtl/dtu_queue.sv
rtl/dtu_back.sv
rtl/dvb_text_iso8859_to_utf8.sv
bench/tb_dvb_text_iso8859_to_utf8.sv
